// ----- src/lcs_pkg.sv -----
`timescale 1ns / 1ps

package lcs_pkg;

  // Fixed field widths of the access and result ports.
  localparam int ADDR_W    = 32;
  localparam int MODE_W    = 2;
  localparam int WAY_OUT_W = 3;
  localparam int COUNT_W   = 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam int BYTE_OFF_W = 2;
  localparam int WORD_OFF_W = 3;
  localparam int SHIFT_W    = 4;

  localparam logic [BYTE_OFF_W-1:0] BYTE_OFF_RESET = 2'd2;
  localparam logic [WORD_OFF_W-1:0] WORD_OFF_RESET = 3'd0;

  // Associativity default and supported range.
  localparam int DEFAULT_WAYS = 8;
  localparam int MAX_WAYS     = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYTE_OFFSET = 1'b0,
    CFG_WORD_OFFSET = 1'b1
  } cfg_index_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_CLEAN = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

endpackage

// ----- src/lcs_lookup.sv -----
`timescale 1ns / 1ps

module lcs_lookup #(
  parameter int WAYS = lcs_pkg::DEFAULT_WAYS,
  parameter int IW   = (WAYS > 1) ? $clog2(WAYS) : 1,
  parameter int RW   = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic [lcs_pkg::ADDR_W-1:0]            address,
  input  logic [lcs_pkg::SHIFT_W-1:0]           shift,
  input  logic [WAYS-1:0][lcs_pkg::ADDR_W-1:0]  tags,
  input  logic [WAYS-1:0]                       valids,
  input  logic [WAYS-1:0][RW-1:0]               ranks,
  output logic [lcs_pkg::ADDR_W-1:0]            blk_tag,
  output logic                                  hit,
  output logic [IW-1:0]                         sel_way
);
  import lcs_pkg::*;

  logic [IW-1:0] hit_way;
  logic [IW-1:0] lru_way;

  assign blk_tag = address >> shift;

  // Lowest matching index wins; scanning downward lets the lowest overwrite.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    lru_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (valids[i] && (tags[i] == blk_tag)) begin
        hit     = 1'b1;
        hit_way = IW'(i);
      end
      if (ranks[i] == '0) begin
        lru_way = IW'(i);
      end
    end
  end

  assign sel_way = hit ? hit_way : lru_way;

endmodule

// ----- src/lcs_rank_update.sv -----
`timescale 1ns / 1ps

module lcs_rank_update #(
  parameter int WAYS = lcs_pkg::DEFAULT_WAYS,
  parameter int IW   = (WAYS > 1) ? $clog2(WAYS) : 1,
  parameter int RW   = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic [WAYS-1:0][RW-1:0] ranks,
  input  logic [IW-1:0]           sel_way,
  output logic [WAYS-1:0][RW-1:0] ranks_new
);
  import lcs_pkg::*;

  localparam logic [RW-1:0] RANK_TOP = RW'(WAYS - 1);

  logic [RW-1:0] old_rank;

  assign old_rank = ranks[sel_way];

  // The touched way becomes most recent; ways more recent than it slide down by one rank.
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      if (IW'(i) == sel_way) begin
        ranks_new[i] = RANK_TOP;
      end else if (ranks[i] > old_rank) begin
        ranks_new[i] = ranks[i] - RW'(1);
      end else begin
        ranks_new[i] = ranks[i];
      end
    end
  end

endmodule

// ----- src/lru_cache_set_unit.sv -----
`timescale 1ns / 1ps

// One set of a set-associative cache with true LRU ranking.
//
// Access channel: an item (mode, address) is accepted at each rising edge
// where start is high and busy is low. busy is always low, so one item can
// be accepted in every cycle. Modes are read, write and clean; the fourth
// code does nothing but still returns an all-zero result.
// Result channel: done is high for exactly one cycle with the result fields.
// An accepted item waits in the input register for its lookup; its result
// is then registered onto the ports with done; the throughput is one item
// per cycle. Lookup, rank update and state write in one pass make
// back-to-back items see each other's effects. The receiver cannot stall
// the result; it must take it at once.
// Configuration: cfg_write with cfg_index selects the byte or word offset
// width; writes take effect immediately and are meant for idle periods.
// Reset (rst, synchronous) clears every tag, valid, dirty and rank, drops
// any item in flight and restores the offsets to 2 and 0.
module lru_cache_set_unit #(
  parameter int WAYS = lcs_pkg::DEFAULT_WAYS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [lcs_pkg::MODE_W-1:0]         mode,
  input  logic [lcs_pkg::ADDR_W-1:0]         address,
  output logic                               done,
  output logic                               hit,
  output logic [lcs_pkg::WAY_OUT_W-1:0]      way,
  output logic                               victim_valid,
  output logic                               victim_dirty,
  output logic [lcs_pkg::ADDR_W-1:0]         victim_tag,
  output logic [lcs_pkg::COUNT_W-1:0]        dirty_count,
  input  logic                               cfg_write,
  input  logic [lcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lcs_pkg::*;

  localparam int IW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W = $clog2(WAYS + 1);
  localparam logic [RW-1:0] RANK_TOP = RW'(WAYS - 1);

  // Configuration registers.
  logic [BYTE_OFF_W-1:0] byte_offset_bits;
  logic [WORD_OFF_W-1:0] word_offset_bits;

  // Input register: the accepted item waits here for its lookup cycle.
  logic              req_valid;
  mode_t             req_mode;
  logic [ADDR_W-1:0] req_addr;

  // Set state.
  logic [WAYS-1:0][ADDR_W-1:0] way_tag, way_tag_next;
  logic [WAYS-1:0]             way_valid, way_valid_next;
  logic [WAYS-1:0]             way_dirty, way_dirty_next;
  logic [WAYS-1:0][RW-1:0]     way_rank, way_rank_next;

  // Result register next values.
  logic                 hit_next;
  logic [WAY_OUT_W-1:0] way_next;
  logic                 victim_valid_next;
  logic                 victim_dirty_next;
  logic [ADDR_W-1:0]    victim_tag_next;
  logic [COUNT_W-1:0]   dirty_count_next;

  // Lookup results.
  logic [SHIFT_W-1:0]      shift;
  logic [ADDR_W-1:0]       lk_tag;
  logic                    lk_hit;
  logic [IW-1:0]           lk_way;
  logic [WAYS-1:0][RW-1:0] rank_new;
  logic [CNT_W-1:0]        dirty_total;

  assign busy = 1'b0;

  // The address drops the byte and word offsets, at most ten bits in all.
  assign shift = SHIFT_W'(byte_offset_bits) + SHIFT_W'(word_offset_bits);

  lcs_lookup #(
    .WAYS (WAYS),
    .IW   (IW),
    .RW   (RW)
  ) u_lookup (
    .address (req_addr),
    .shift   (shift),
    .tags    (way_tag),
    .valids  (way_valid),
    .ranks   (way_rank),
    .blk_tag (lk_tag),
    .hit     (lk_hit),
    .sel_way (lk_way)
  );

  lcs_rank_update #(
    .WAYS (WAYS),
    .IW   (IW),
    .RW   (RW)
  ) u_rank (
    .ranks     (way_rank),
    .sel_way   (lk_way),
    .ranks_new (rank_new)
  );

  assign dirty_total = CNT_W'($countones(way_dirty));

  // One pass per item: state update and result computed together, so the
  // next item in the input register already sees this item's changes.
  always_comb begin
    way_tag_next      = way_tag;
    way_valid_next    = way_valid;
    way_dirty_next    = way_dirty;
    way_rank_next     = way_rank;
    hit_next          = 1'b0;
    way_next          = '0;
    victim_valid_next = 1'b0;
    victim_dirty_next = 1'b0;
    victim_tag_next   = '0;
    dirty_count_next  = '0;
    if (req_valid) begin
      unique case (req_mode)
        MODE_READ, MODE_WRITE: begin
          way_next = WAY_OUT_W'(lk_way);
          if (lk_hit) begin
            hit_next = 1'b1;
          end else begin
            // Miss: report what the least recent way held, then refill it.
            victim_valid_next      = way_valid[lk_way];
            victim_dirty_next      = way_dirty[lk_way];
            victim_tag_next        = way_tag[lk_way];
            way_tag_next[lk_way]   = lk_tag;
            way_valid_next[lk_way] = 1'b1;
            way_dirty_next[lk_way] = 1'b0;
          end
          way_rank_next = rank_new;
          if (req_mode == MODE_WRITE) begin
            way_dirty_next[lk_way] = 1'b1;
          end
        end
        MODE_CLEAN: begin
          dirty_count_next = COUNT_W'(dirty_total);
          way_dirty_next   = '0;
        end
        MODE_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset_bits <= BYTE_OFF_RESET;
      word_offset_bits <= WORD_OFF_RESET;
      req_valid        <= 1'b0;
      done             <= 1'b0;
      way_tag          <= '0;
      way_valid        <= '0;
      way_dirty        <= '0;
      way_rank         <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_BYTE_OFFSET: byte_offset_bits <= cfg_data[BYTE_OFF_W-1:0];
          CFG_WORD_OFFSET: word_offset_bits <= cfg_data[WORD_OFF_W-1:0];
          default: begin
          end
        endcase
      end
      req_valid <= start && !busy;
      done      <= req_valid;
      way_tag   <= way_tag_next;
      way_valid <= way_valid_next;
      way_dirty <= way_dirty_next;
      way_rank  <= way_rank_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_mode <= mode_t'(mode);
      req_addr <= address;
    end
    hit          <= hit_next;
    way          <= way_next;
    victim_valid <= victim_valid_next;
    victim_dirty <= victim_dirty_next;
    victim_tag   <= victim_tag_next;
    dirty_count  <= dirty_count_next;
  end

  // Every result strobe comes from an item accepted earlier by start.
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2))
    else $error("result strobe without an accepted item");

  // A hit never reports a victim.
  a_hit_no_victim: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (!victim_valid && !victim_dirty))
    else $error("hit reported with a victim");

  // The way touched by an access becomes the most recent.
  a_touched_is_mru: assert property (@(posedge clk) disable iff (rst)
    ($past(req_valid) && ($past(req_mode) == MODE_READ || $past(req_mode) == MODE_WRITE)
      && !$past(rst)) |-> (way_rank[$past(lk_way)] == RANK_TOP))
    else $error("accessed way not promoted to most recent");

  // A clean request leaves no dirty way behind.
  a_clean_clears: assert property (@(posedge clk) disable iff (rst)
    ($past(req_valid) && $past(req_mode) == MODE_CLEAN && !$past(rst))
      |-> (way_dirty == '0))
    else $error("dirty marks survive a clean");

  // A write access leaves its way dirty and valid.
  a_write_dirty: assert property (@(posedge clk) disable iff (rst)
    ($past(req_valid) && $past(req_mode) == MODE_WRITE && !$past(rst))
      |-> (way_dirty[$past(lk_way)] && way_valid[$past(lk_way)]))
    else $error("written way not marked dirty");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

import lcs_pkg::*;

// Result fields of one lookup, in port order.
typedef struct packed {
  logic                 hit;
  logic [WAY_OUT_W-1:0] way;
  logic                 victim_valid;
  logic                 victim_dirty;
  logic [ADDR_W-1:0]    victim_tag;
  logic [COUNT_W-1:0]   dirty_count;
} lookup_result_t;

// Shadow copy of the cache set. It replays every accepted item and keeps the
// lookup results that the block still owes, oldest first.
class lru_set_tracker;
  localparam int NWAYS = DEFAULT_WAYS;

  logic [ADDR_W-1:0]     tag_q [NWAYS];
  bit                    valid_q [NWAYS];
  bit                    dirty_q [NWAYS];
  int                    rank_q [NWAYS];
  logic [BYTE_OFF_W-1:0] byte_off;
  logic [WORD_OFF_W-1:0] word_off;
  lookup_result_t        owed_results [$];
  int                    mismatches;

  function new();
    for (int i = 0; i < NWAYS; i++) begin
      tag_q[i]   = '0;
      valid_q[i] = 1'b0;
      dirty_q[i] = 1'b0;
      rank_q[i]  = 0;
    end
    byte_off   = BYTE_OFF_RESET;
    word_off   = WORD_OFF_RESET;
    mismatches = 0;
  endfunction

  function int pending();
    return owed_results.size();
  endfunction

  // Offset shift of the block address under the current settings.
  function int block_shift();
    return int'(byte_off) + int'(word_off);
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function void load_offset(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_BYTE_OFFSET) begin
      byte_off = data[BYTE_OFF_W-1:0];
    end else begin
      word_off = data[WORD_OFF_W-1:0];
    end
  endfunction

  // Moves a way to most recent; every way ranked above it drops by one.
  function void promote(int w);
    int old;
    old = rank_q[w];
    for (int i = 0; i < NWAYS; i++) begin
      if (rank_q[i] > old) rank_q[i]--;
    end
    rank_q[w] = NWAYS - 1;
  endfunction

  function void take_access(mode_t m, logic [ADDR_W-1:0] addr);
    lookup_result_t r;
    logic [ADDR_W-1:0] blk;
    bit found;
    int w;
    int cnt;
    r = '0;
    case (m)
      MODE_CLEAN: begin
        cnt = 0;
        for (int i = 0; i < NWAYS; i++) begin
          if (dirty_q[i]) cnt++;
          dirty_q[i] = 1'b0;
        end
        r.dirty_count = cnt[COUNT_W-1:0];
      end
      MODE_READ, MODE_WRITE: begin
        blk   = addr >> block_shift();
        found = 1'b0;
        w     = 0;
        for (int i = 0; i < NWAYS; i++) begin
          if (!found && valid_q[i] && tag_q[i] == blk) begin
            found = 1'b1;
            w     = i;
          end
        end
        if (!found) begin
          // Victim is the lowest-numbered way among the least recent.
          for (int i = NWAYS - 1; i >= 0; i--) begin
            if (rank_q[i] == 0) w = i;
          end
          r.victim_valid = valid_q[w];
          r.victim_dirty = dirty_q[w];
          r.victim_tag   = tag_q[w];
          tag_q[w]       = blk;
          valid_q[w]     = 1'b1;
          dirty_q[w]     = 1'b0;
        end
        promote(w);
        if (m == MODE_WRITE) dirty_q[w] = 1'b1;
        r.hit = found;
        r.way = w[WAY_OUT_W-1:0];
      end
      default: begin
        // The spare mode code leaves the set alone and owes a zero result.
      end
    endcase
    owed_results = {owed_results, r};
  endfunction

  task compare_field(string name, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
    if (got !== want) report($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  task match_result(lookup_result_t got);
    lookup_result_t want;
    if (owed_results.size() == 0) begin
      report("result strobe with no item outstanding");
    end else begin
      want = owed_results.pop_front();
      compare_field("hit", got.hit, want.hit);
      compare_field("way", got.way, want.way);
      compare_field("victim_valid", got.victim_valid, want.victim_valid);
      compare_field("victim_dirty", got.victim_dirty, want.victim_dirty);
      compare_field("victim_tag", got.victim_tag, want.victim_tag);
      compare_field("dirty_count", got.dirty_count, want.dirty_count);
    end
  endtask
endclass

module testbench;

  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int MAX_POOL = 16;
  // The result of an item comes back through the input and result registers;
  // the settle cycles give the pipeline time to empty before settings change.
  localparam int SETTLE_CYCLES = 4;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic [MODE_W-1:0]     mode = '0;
  logic [ADDR_W-1:0]     address = '0;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                  busy;
  logic                  done;
  logic                  hit;
  logic [WAY_OUT_W-1:0]  way;
  logic                  victim_valid;
  logic                  victim_dirty;
  logic [ADDR_W-1:0]     victim_tag;
  logic [COUNT_W-1:0]    dirty_count;

  lru_set_tracker sb = new();

  // Block addresses that the random accesses keep coming back to, so that
  // the set sees hits, refills and dirty evictions rather than cold misses.
  logic [ADDR_W-1:0] block_pool [MAX_POOL];
  int                pool_size;

  lru_cache_set_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .address      (address),
    .done         (done),
    .hit          (hit),
    .way          (way),
    .victim_valid (victim_valid),
    .victim_dirty (victim_dirty),
    .victim_tag   (victim_tag),
    .dirty_count  (dirty_count),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Everything the testbench drives changes by nonblocking assignment at
  // the rising edge, so the values read here are the ones the block saw at
  // this edge. Results are checked, accepted items are replayed on the
  // shadow set and register writes are mirrored, all in the same place.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        sb.match_result('{hit, way, victim_valid, victim_dirty, victim_tag, dirty_count});
      end
      if (start && !busy) sb.take_access(mode_t'(mode), address);
      if (cfg_write) sb.load_offset(cfg_index, cfg_data);
    end
  end

  // Presents one item and holds it until the block takes it. start stays
  // high on return so that back-to-back items leave no gap.
  task automatic send_item(input mode_t m, input logic [ADDR_W-1:0] a);
    start   <= 1'b1;
    mode    <= m;
    address <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stops sending and waits until every owed result has come back, then
  // lets the pipeline settle. Counts are read at the falling edge, where
  // the monitor has finished its work for the cycle.
  task automatic wait_drain();
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes only ever happen with the set idle.
  task automatic write_offset(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    wait_drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Byte offset only uses the low bits of the data; the top bit is random so
  // that every data bit is exercised on both registers.
  task automatic set_offsets(input int byte_bits, input int word_bits);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(byte_bits);
    data[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
    write_offset(CFG_BYTE_OFFSET, data);
    write_offset(CFG_WORD_OFFSET, CFG_DATA_W'(word_bits));
  endtask

  task automatic fill_pool();
    int shift;
    shift = sb.block_shift();
    pool_size = $urandom_range(4, MAX_POOL);
    for (int i = 0; i < MAX_POOL; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        block_pool[i] = ADDR_W'($urandom_range(0, 15)) >> shift;
      end else begin
        block_pool[i] = $urandom >> shift;
      end
    end
  endtask

  function automatic mode_t pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return MODE_READ;
    if (r < 85) return MODE_WRITE;
    if (r < 95) return MODE_CLEAN;
    return MODE_NONE;
  endfunction

  // Mostly addresses inside the pool with random offset bits below the
  // block address; the rest are unrelated addresses that almost always miss.
  function automatic logic [ADDR_W-1:0] pick_address();
    int shift;
    logic [ADDR_W-1:0] low_mask;
    shift = sb.block_shift();
    low_mask = (ADDR_W'(1) << shift) - 1;
    if ($urandom_range(0, 9) < 8) begin
      return (block_pool[$urandom_range(0, pool_size - 1)] << shift) | ($urandom & low_mask);
    end
    return $urandom;
  endfunction

  initial begin
    int idle_pct;
    int byte_bits;
    int word_bits;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, under the reset offsets: a miss on address zero into an
    // empty set where every way ties for least recent, a hit on the same
    // block through a different byte, the all-ones address, the spare mode,
    // cleans with and without dirty ways, then enough writes and reads to
    // wrap the set and push dirty blocks out, a clean, a write hit and a read miss.
    send_item(MODE_READ, '0);
    send_item(MODE_READ, 32'h0000_0003);
    send_item(MODE_WRITE, 32'hFFFF_FFFF);
    send_item(MODE_NONE, 32'hFFFF_FFFF);
    send_item(MODE_CLEAN, 32'h1234_5678);
    send_item(MODE_CLEAN, '0);
    for (int k = 1; k <= 8; k++) send_item(MODE_WRITE, ADDR_W'(k * 4 + 1));
    for (int k = 9; k <= 12; k++) send_item(MODE_READ, ADDR_W'(k * 4));
    send_item(MODE_CLEAN, '0);
    send_item(MODE_WRITE, ADDR_W'(9 * 4 + 2));
    send_item(MODE_READ, 32'h8000_0000);

    // Random part, one phase per offset setting. The first settings cover
    // the smallest and largest shifts; the last phase runs without gaps.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin byte_bits = 0; word_bits = 0; end
        1: begin byte_bits = 3; word_bits = 7; end
        2: begin byte_bits = 3; word_bits = 6; end
        3: begin byte_bits = 0; word_bits = 7; end
        4: begin byte_bits = 1; word_bits = 3; end
        default: begin
          byte_bits = $urandom_range(0, 3);
          word_bits = $urandom_range(0, 7);
        end
      endcase
      set_offsets(byte_bits, word_bits);
      fill_pool();
      idle_pct = (p == RANDOM_PHASES - 1) ? 0 : $urandom_range(0, 40);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(pick_mode(), pick_address());
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          idle_cycles($urandom_range(1, 14));
        end else if (idle_pct != 0 && $urandom_range(0, 49) == 0) begin
          wait_drain();
        end
      end
    end

    // Wind down: collect what is still owed, within a bound.
    start <= 1'b0;
    for (int n = 0; n < 200 && sb.pending() != 0; n++) @(negedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/lcs_pkg.sv
src/lcs_lookup.sv
src/lcs_rank_update.sv
src/lru_cache_set_unit.sv
sim/testbench.sv
